// ===== rtl/core/maze_dfs_generator_defines.svh =====
// ----------------------------------------------------------------------------
// Maze DFS generator assertion macros
// Concurrent assertion helpers used by the maze generator RTL.
// ----------------------------------------------------------------------------
`ifndef MAZE_DFS_GENERATOR_DEFINES_SVH
`define MAZE_DFS_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MDG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define MDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MDG_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define MDG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== rtl/core/mdg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze DFS generator package
// Shared widths, codes, types and helper functions of the maze generator.
// ----------------------------------------------------------------------------
package mdg_pkg;

  localparam int MAX_SIDE = 16;
  localparam int COORD_W  = $clog2(MAX_SIDE);
  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int CELL_W   = $clog2(CELLS);
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int NUM_DIRS = 4;

  localparam int FUNC_W  = 1;
  localparam int RAND_W  = 16;
  localparam int MOVE_W  = 3;
  localparam int POS_W   = 4;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(4);
  localparam logic [SIDE_W-1:0] SIDE_MIN   = SIDE_W'(2);
  localparam logic [SIDE_W-1:0] SIDE_MAX   = SIDE_W'(MAX_SIDE);

  localparam logic [FUNC_W-1:0] FUNC_CARVE   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 1'b1;

  typedef enum logic [1:0] {
    DIR_LEFT,
    DIR_RIGHT,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef enum logic [MOVE_W-1:0] {
    MOVE_LEFT,
    MOVE_RIGHT,
    MOVE_UP,
    MOVE_DOWN,
    MOVE_BACK,
    MOVE_NONE
  } move_e;

  typedef struct packed {
    logic found;
    dir_e dir;
  } pick_t;

  function automatic dir_e opposite(input dir_e d);
    dir_e r;
    case (d)
      DIR_LEFT:  r = DIR_RIGHT;
      DIR_RIGHT: r = DIR_LEFT;
      DIR_UP:    r = DIR_DOWN;
      DIR_DOWN:  r = DIR_UP;
      default:   r = DIR_LEFT;
    endcase
    return r;
  endfunction

  // Base-4 digits all weigh one modulo three, so the digit sum keeps the residue.
  function automatic logic [1:0] mod3_rand(input logic [RAND_W-1:0] v);
    logic [4:0] s;
    logic [2:0] t;
    s = '0;
    for (int i = 0; i < RAND_W / 2; i++) begin
      s = s + 5'(v[2*i +: 2]);
    end
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    if (t >= 3'd6) begin
      t = t - 3'd6;
    end else if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

endpackage

// ===== rtl/core/mdg_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze DFS generator channels
// Valid/ready interfaces for step requests and step results.
// ----------------------------------------------------------------------------
interface mdg_in_if import mdg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [RAND_W-1:0] random_value;

  modport source (output valid, output func, output random_value, input ready);
  modport sink (input valid, input func, input random_value, output ready);
endinterface

interface mdg_out_if import mdg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MOVE_W-1:0] move;
  logic [POS_W-1:0]  pos_x;
  logic [POS_W-1:0]  pos_y;
  logic              done_res;

  modport source (output valid, output move, output pos_x, output pos_y,
                  output done_res, input ready);
  modport sink (input valid, input move, input pos_x, input pos_y,
                input done_res, output ready);
endinterface

// ===== rtl/core/mdg_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze DFS direction picker
// Selects the open direction at index random modulo the number of open ones.
// ----------------------------------------------------------------------------
module mdg_pick import mdg_pkg::*; (
  input  logic [NUM_DIRS-1:0] open_i,
  input  logic [RAND_W-1:0]   rnd_i,
  input  logic [1:0]          rnd_mod3_i,
  output pick_t               pick_o
);

  logic [2:0] cnt;
  logic [1:0] idx;
  logic [2:0] seen;
  logic       hit;
  dir_e       dir;

  always_comb begin
    cnt = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      cnt = cnt + 3'(open_i[d]);
    end
    case (cnt)
      3'd2:    idx = {1'b0, rnd_i[0]};
      3'd3:    idx = rnd_mod3_i;
      3'd4:    idx = rnd_i[1:0];
      default: idx = '0;
    endcase
    seen = '0;
    hit  = 1'b0;
    dir  = DIR_LEFT;
    for (int d = 0; d < NUM_DIRS; d++) begin
      if (open_i[d]) begin
        if (!hit && (seen == {1'b0, idx})) begin
          dir = dir_e'(2'(d));
          hit = 1'b1;
        end
        seen = seen + 3'd1;
      end
    end
  end

  assign pick_o.found = |open_i;
  assign pick_o.dir   = dir;

endmodule

// ===== rtl/core/maze_dfs_generator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Maze DFS generator
// Recursive-backtracker maze carving, one move per step transaction.
// ----------------------------------------------------------------------------
// A step transaction first reads the left and right neighbours from the two
// read ports of the visited memory, then the up and down neighbours and the
// stored back direction, and then, once the output register can take the
// result, decides the move; a forward move writes both memories, a back step
// only the visited one. The visited memory has two read ports and one write
// port. The result waits in an output register; the next step is taken once
// the result has been loaded. After reset and after every restart the visited
// memory is cleared by a pass over all 256 cells, one cell per cycle, during
// which no step is accepted; configuration writes are taken at any time.
`include "maze_dfs_generator_defines.svh"

module maze_dfs_generator import mdg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  mdg_in_if.sink            in_ch,
  mdg_out_if.source         out_ch,
  input  logic              cfg_we_i,
  input  logic [SIDE_W-1:0] cfg_wdata_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RD2   = 2'd1;
  localparam logic [1:0] ST_EXE   = 2'd2;
  localparam logic [1:0] ST_CLEAR = 2'd3;
  localparam int PROD_W = 2 * SIDE_W;

  logic [1:0]         state_q, state_d;
  logic [SIDE_W-1:0]  side_q;
  logic [COORD_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CELL_W-1:0]  fwd_q, fwd_d;
  logic               fin_q, fin_d;
  logic [CELL_W-1:0]  clr_cnt_q, clr_cnt_d;

  logic [FUNC_W-1:0]  func_q;
  logic [RAND_W-1:0]  rnd_q;
  logic [1:0]         rnd_mod3_q;
  logic [1:0]         lr_q;

  logic               vis_mem [CELLS];
  logic               vis_a_q, vis_b_q;
  logic [1:0]         back_mem [CELLS];
  logic [1:0]         back_rd_q;

  logic               out_valid_q;
  move_e              out_move_q, move_d;
  logic [POS_W-1:0]   out_x_q, out_y_q;
  logic               out_done_q;

  logic               accept, adv, vis_re, vis_we, vis_wdata, back_we;
  logic [CELL_W-1:0]  rd_a_addr, rd_b_addr, vis_waddr, back_waddr, cur_addr;
  logic [1:0]         back_wdata;
  logic [SIDE_W-1:0]  side_use, x_e, y_e;
  logic [PROD_W-1:0]  side_sq;
  logic [CELL_W-1:0]  target;
  logic [NUM_DIRS-1:0] ok, open;
  logic [COORD_W-1:0] nx, ny, bx, by;
  logic               back_ok;
  pick_t              pick;

  always_comb begin
    side_use = side_q;
    if (side_q < SIDE_MIN) begin
      side_use = SIDE_MIN;
    end else if (side_q > SIDE_MAX) begin
      side_use = SIDE_MAX;
    end
  end

  assign side_sq = PROD_W'(side_use) * PROD_W'(side_use);
  assign target  = CELL_W'(side_sq - PROD_W'(1));

  assign accept   = in_ch.valid && in_ch.ready;
  assign adv      = !out_valid_q || out_ch.ready;
  assign cur_addr = {cur_y_q, cur_x_q};
  assign x_e      = SIDE_W'(cur_x_q);
  assign y_e      = SIDE_W'(cur_y_q);

  assign in_ch.ready = (state_q == ST_IDLE);

  // Left and right are read at acceptance, up and down in the following cycle.
  assign vis_re    = accept || (state_q == ST_RD2);
  assign rd_a_addr = (state_q == ST_RD2) ? {cur_y_q - COORD_W'(1), cur_x_q}
                                         : {cur_y_q, cur_x_q - COORD_W'(1)};
  assign rd_b_addr = (state_q == ST_RD2) ? {cur_y_q + COORD_W'(1), cur_x_q}
                                         : {cur_y_q, cur_x_q + COORD_W'(1)};

  always_comb begin
    ok[DIR_LEFT]  = (cur_x_q != '0) && ((x_e - SIDE_W'(1)) < side_use) && (y_e < side_use);
    ok[DIR_RIGHT] = ((x_e + SIDE_W'(1)) < side_use) && (y_e < side_use);
    ok[DIR_UP]    = (cur_y_q != '0) && (x_e < side_use) && ((y_e - SIDE_W'(1)) < side_use);
    ok[DIR_DOWN]  = ((y_e + SIDE_W'(1)) < side_use) && (x_e < side_use);
    open[DIR_LEFT]  = ok[DIR_LEFT] && !lr_q[0];
    open[DIR_RIGHT] = ok[DIR_RIGHT] && !lr_q[1];
    open[DIR_UP]    = ok[DIR_UP] && !vis_a_q;
    open[DIR_DOWN]  = ok[DIR_DOWN] && !vis_b_q;
  end

  mdg_pick u_pick (
    .open_i     (open),
    .rnd_i      (rnd_q),
    .rnd_mod3_i (rnd_mod3_q),
    .pick_o     (pick)
  );

  always_comb begin
    nx = cur_x_q;
    ny = cur_y_q;
    case (pick.dir)
      DIR_LEFT:  nx = cur_x_q - COORD_W'(1);
      DIR_RIGHT: nx = cur_x_q + COORD_W'(1);
      DIR_UP:    ny = cur_y_q - COORD_W'(1);
      DIR_DOWN:  ny = cur_y_q + COORD_W'(1);
      default:   nx = cur_x_q;
    endcase
  end

  // A back step is bounded by the storage area, not by the side in use.
  always_comb begin
    bx      = cur_x_q;
    by      = cur_y_q;
    back_ok = 1'b0;
    case (dir_e'(back_rd_q))
      DIR_LEFT: begin
        back_ok = (cur_x_q != '0);
        bx      = cur_x_q - COORD_W'(1);
      end
      DIR_RIGHT: begin
        back_ok = (cur_x_q != COORD_W'(MAX_SIDE - 1));
        bx      = cur_x_q + COORD_W'(1);
      end
      DIR_UP: begin
        back_ok = (cur_y_q != '0);
        by      = cur_y_q - COORD_W'(1);
      end
      DIR_DOWN: begin
        back_ok = (cur_y_q != COORD_W'(MAX_SIDE - 1));
        by      = cur_y_q + COORD_W'(1);
      end
      default: back_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    fwd_d      = fwd_q;
    fin_d      = fin_q;
    clr_cnt_d  = clr_cnt_q;
    move_d     = MOVE_NONE;
    vis_we     = 1'b0;
    vis_waddr  = cur_addr;
    vis_wdata  = 1'b1;
    back_we    = 1'b0;
    back_waddr = {ny, nx};
    back_wdata = opposite(pick.dir);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RD2;
        end
      end
      ST_RD2: begin
        state_d = ST_EXE;
      end
      ST_EXE: begin
        if (adv) begin
          state_d = ST_IDLE;
          if (func_q == FUNC_RESTART) begin
            cur_x_d   = '0;
            cur_y_d   = '0;
            fwd_d     = '0;
            fin_d     = 1'b0;
            clr_cnt_d = '0;
            state_d   = ST_CLEAR;
          end else if (fin_q || (fwd_q >= target)) begin
            fin_d = 1'b1;
          end else if (pick.found) begin
            vis_we  = 1'b1;
            back_we = 1'b1;
            cur_x_d = nx;
            cur_y_d = ny;
            fwd_d   = fwd_q + CELL_W'(1);
            fin_d   = ((fwd_q + CELL_W'(1)) >= target);
            move_d  = move_e'({1'b0, pick.dir});
          end else if ((cur_x_q != '0) || (cur_y_q != '0)) begin
            vis_we = 1'b1;
            if (back_ok) begin
              cur_x_d = bx;
              cur_y_d = by;
            end
            move_d = MOVE_BACK;
          end
        end
      end
      ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_waddr = clr_cnt_q;
        vis_wdata = 1'b0;
        clr_cnt_d = clr_cnt_q + CELL_W'(1);
        if (clr_cnt_q == CELL_W'(CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      side_q      <= SIDE_RESET;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      fwd_q       <= '0;
      fin_q       <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_x_q   <= cur_x_d;
      cur_y_q   <= cur_y_d;
      fwd_q     <= fwd_d;
      fin_q     <= fin_d;
      clr_cnt_q <= clr_cnt_d;
      if (cfg_we_i) begin
        side_q <= cfg_wdata_i;
      end
      if ((state_q == ST_EXE) && adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= in_ch.func;
      rnd_q  <= in_ch.random_value;
    end
    if (state_q == ST_RD2) begin
      lr_q       <= {vis_b_q, vis_a_q};
      rnd_mod3_q <= mod3_rand(rnd_q);
    end
    if ((state_q == ST_EXE) && adv) begin
      out_move_q <= move_d;
      out_x_q    <= POS_W'(cur_x_d);
      out_y_q    <= POS_W'(cur_y_d);
      out_done_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    if (vis_re) begin
      vis_a_q <= vis_mem[rd_a_addr];
      vis_b_q <= vis_mem[rd_b_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (back_we) begin
      back_mem[back_waddr] <= back_wdata;
    end
    if (state_q == ST_RD2) begin
      back_rd_q <= back_mem[cur_addr];
    end
  end

  assign out_ch.valid    = out_valid_q;
  assign out_ch.move     = out_move_q;
  assign out_ch.pos_x    = out_x_q;
  assign out_ch.pos_y    = out_y_q;
  assign out_ch.done_res = out_done_q;

  `MDG_ASSERT_NEXT(a_accept_reads, clk_i, rst_ni, accept, state_q == ST_RD2, "accepted step did not start its second read")
  `MDG_ASSERT_NEXT(a_restart_clears, clk_i, rst_ni, (state_q == ST_EXE) && adv && (func_q == FUNC_RESTART), (state_q == ST_CLEAR) && (clr_cnt_q == '0), "restart did not start a clearing pass")
  `MDG_ASSERT_IMPLY(a_result_from_exe, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_EXE, "result appeared outside the execute cycle")
  `MDG_ASSERT_IMPLY(a_done_not_back, clk_i, rst_ni, out_valid_q && out_done_q, out_move_q != MOVE_BACK, "finished maze reported a back step")

endmodule
